// File: rtl/core/rfra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfra_pkg
// Shared types and constants for the ring FIFO with running mean.
// ----------------------------------------------------------------------------
package rfra_pkg;

  localparam int unsigned KEY_W  = 16;
  localparam int unsigned RATE_W = 8;
  localparam int unsigned MEAN_W = 8;
  localparam int unsigned OCC_W  = 6;
  localparam int unsigned STAT_W = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_FIN
  } fsm_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [RATE_W-1:0] rate;
  } slot_t;

  typedef struct packed {
    status_e           status;
    logic [MEAN_W-1:0] mean;
    logic [KEY_W-1:0]  pkey;
    logic [RATE_W-1:0] prate;
    logic [OCC_W-1:0]  occ;
  } res_t;

  // control strobes from the sequencer
  typedef struct packed {
    logic in_rdy;
    logic acc;
    logic mem_we;
    logic mem_re;
    logic div_start;
    logic out_load;
  } ctl_t;

endpackage

// File: rtl/core/rfra_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfra_in_if / rfra_out_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface rfra_in_if import rfra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [KEY_W-1:0]  entry_key;
  logic [RATE_W-1:0] entry_rate;

  modport source (output valid, output opcode, output entry_key, output entry_rate,
                  input ready);
  modport sink   (input valid, input opcode, input entry_key, input entry_rate,
                  output ready);
endinterface

interface rfra_out_if import rfra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [MEAN_W-1:0] mean_rate;
  logic [KEY_W-1:0]  popped_key;
  logic [RATE_W-1:0] popped_rate;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output mean_rate, output popped_key,
                  output popped_rate, output occupancy, input ready);
  modport sink   (input valid, input status, input mean_rate, input popped_key,
                  input popped_rate, input occupancy, output ready);
endinterface

// File: rtl/core/rfra_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfra_slot_mem
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rfra_slot_mem import rfra_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  slot_t            wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output slot_t            rdata_o
);

  slot_t mem [DEPTH];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/rfra_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfra_div
// Restoring divider, one quotient bit per cycle; quotient known to fit MEAN_W.
// ----------------------------------------------------------------------------
module rfra_div import rfra_pkg::*; #(
  parameter int unsigned SUM_W = 14,
  parameter int unsigned CNT_W = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [MEAN_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(MEAN_W);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  den_q, den_d;
  logic [MEAN_W-1:0] quo_q, quo_d;
  logic              ge;

  assign ge = (rem_q >= den_q);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(MEAN_W - 1);
      rem_d  = dividend_i;
      // divisor aligned to the top quotient bit
      den_d  = SUM_W'({divisor_i, {(MEAN_W-1){1'b0}}});
      quo_d  = '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - den_q;
      end
      den_d  = den_q >> 1;
      quo_d  = {quo_q[MEAN_W-2:0], ge};
      step_d = step_q - STEP_W'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o     = busy_q && (step_q == '0);
  assign quotient_o = {quo_q[MEAN_W-2:0], ge};

endmodule

// File: rtl/core/ring_fifo_running_average.sv
`timescale 1ns / 1ps
// Successful push: the beat is accepted in IDLE, the mean is divided out in DIV,
//   then the result is loaded to the output from FIN.
// Successful pop: IDLE, then READ (one slot memory read), then FIN.
// Dropped push / empty pop: IDLE, then straight to FIN.
// One beat in flight; a new beat is taken while the previous result waits.
// rst_ni clears pointers, count, sum and handshake state; slots are not cleared.
// ----------------------------------------------------------------------------
// ring_fifo_running_average
// Circular FIFO of DEPTH slots (DEPTH-1 usable) with running mean of rates.
// ----------------------------------------------------------------------------
module ring_fifo_running_average import rfra_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rfra_in_if.sink      in_i,
  rfra_out_if.source   out_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = IDX_W;
  localparam int unsigned SUM_W = RATE_W + IDX_W;

  fsm_e              state_q, state_d;
  ctl_t              ctl;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              out_vld_q, out_vld_d;
  res_t              res_q, res_d;
  res_t              out_q;
  logic              is_push, full, empty;
  slot_t             wslot, rslot;
  logic              div_done;
  logic [MEAN_W-1:0] div_quo;
  logic [IDX_W:0]    ring_diff, ring_fill;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  assign is_push = (in_i.opcode == OP_PUSH);
  assign full    = (next_idx(tail_q) == head_q);
  assign empty   = (head_q == tail_q);

  // sequencer outputs
  always_comb begin
    ctl           = '0;
    ctl.in_rdy    = (state_q == S_IDLE);
    ctl.acc       = ctl.in_rdy && in_i.valid;
    ctl.mem_we    = ctl.acc && is_push && !full;
    ctl.mem_re    = ctl.acc && !is_push && !empty;
    ctl.div_start = ctl.mem_we;
    ctl.out_load  = (state_q == S_FIN) && (!out_vld_q || out_o.ready);
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (ctl.mem_we) begin
          state_d = S_DIV;
        end else if (ctl.mem_re) begin
          state_d = S_READ;
        end else if (ctl.acc) begin
          state_d = S_FIN;
        end
      end
      S_READ: state_d = S_FIN;
      S_DIV: begin
        if (div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (ctl.out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // pointers, running sum, staged result
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    res_d  = res_q;
    if (ctl.acc) begin
      if (ctl.mem_we) begin
        tail_d = next_idx(tail_q);
        cnt_d  = cnt_q + CNT_W'(1);
        sum_d  = sum_q + SUM_W'(in_i.entry_rate);
      end else if (ctl.mem_re) begin
        head_d = next_idx(head_q);
        cnt_d  = cnt_q - CNT_W'(1);
      end
      res_d.status = !is_push ? (empty ? ST_EMPTY : ST_DONE) : (full ? ST_FULL : ST_DONE);
      res_d.mean   = '0;
      res_d.pkey   = '0;
      res_d.prate  = '0;
      res_d.occ    = OCC_W'(cnt_d);
    end else if (state_q == S_READ) begin
      res_d.pkey  = rslot.key;
      res_d.prate = rslot.rate;
      sum_d       = sum_q - SUM_W'(rslot.rate);
    end else if ((state_q == S_DIV) && div_done) begin
      res_d.mean = div_quo;
    end
  end

  assign out_vld_d = ctl.out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
      sum_q     <= sum_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (ctl.out_load) begin
      out_q <= res_q;
    end
  end

  assign wslot.key  = in_i.entry_key;
  assign wslot.rate = in_i.entry_rate;

  rfra_slot_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (ctl.mem_we),
    .waddr_i (tail_q),
    .wdata_i (wslot),
    .re_i    (ctl.mem_re),
    .raddr_i (head_q),
    .rdata_o (rslot)
  );

  rfra_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i (sum_d),
    .divisor_i  (cnt_d),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_i.ready        = ctl.in_rdy;
  assign out_o.valid       = out_vld_q;
  assign out_o.status      = out_q.status;
  assign out_o.mean_rate   = out_q.mean;
  assign out_o.popped_key  = out_q.pkey;
  assign out_o.popped_rate = out_q.prate;
  assign out_o.occupancy   = out_q.occ;

  // fill level implied by the pointers
  assign ring_diff = {1'b0, tail_q} - {1'b0, head_q};
  assign ring_fill = (tail_q >= head_q) ? ring_diff : ring_diff + (IDX_W+1)'(DEPTH);

  a_cnt_matches_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == ring_fill[IDX_W-1:0])
    else $error("entry count out of step with head/tail pointers");

  // a pop takes its rate out of the sum in the cycle after the count drops
  a_empty_sum_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt_q == '0) && (state_q != S_READ)) |-> (sum_q == '0))
    else $error("running sum nonzero on empty queue");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside divide state");

  a_read_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> $past(ctl.mem_re))
    else $error("read state without a slot read the cycle before");

endmodule

// File: tb/fifo_mean_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_mean_scoreboard
// Watches the request and result channels of the ring FIFO. Keeps its own
// copy of the queue, the running rate sum and the entry count, works out the
// result of every accepted request beat and compares each accepted result
// beat field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module fifo_mean_scoreboard import rfra_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  rfra_in_if   mon_in_i,
  rfra_out_if  mon_out_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);

  slot_t            slots [DEPTH];
  logic [IDX_W-1:0] head_q;
  logic [IDX_W-1:0] tail_q;
  int unsigned      held_n;
  int unsigned      rate_total;
  res_t             results_due [$];
  int               fails;

  function automatic logic [IDX_W-1:0] wrap_inc(logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  // Updates the shadow queue and returns the result the block owes.
  function automatic res_t apply_request(logic op, logic [KEY_W-1:0] key,
                                         logic [RATE_W-1:0] rate);
    res_t r;
    r = '0;
    r.status = ST_DONE;
    if (op == OP_PUSH) begin
      if (wrap_inc(tail_q) == head_q) begin
        r.status = ST_FULL;
      end else begin
        slots[tail_q].key  = key;
        slots[tail_q].rate = rate;
        rate_total += 32'(rate);
        tail_q = wrap_inc(tail_q);
        held_n++;
        r.mean = MEAN_W'(rate_total / held_n);
      end
    end else if (head_q == tail_q) begin
      r.status = ST_EMPTY;
    end else begin
      r.pkey  = slots[head_q].key;
      r.prate = slots[head_q].rate;
      rate_total -= 32'(slots[head_q].rate);
      head_q = wrap_inc(head_q);
      held_n--;
    end
    r.occ = OCC_W'(held_n);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      head_q     = '0;
      tail_q     = '0;
      held_n     = 0;
      rate_total = 0;
      results_due.delete();
      fails      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // result side first: a result never leaves in the cycle its request enters
      if (mon_out_i.valid === 1'b1 && mon_out_i.ready === 1'b1) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing due (status %0d)",
                                    mon_out_i.status));
        end else begin
          want = results_due.pop_front();
          if (mon_out_i.status !== want.status)
            report_mismatch($sformatf("status got %0d, want %0d",
                                      mon_out_i.status, want.status));
          if (mon_out_i.mean_rate !== want.mean)
            report_mismatch($sformatf("mean_rate got %0d, want %0d",
                                      mon_out_i.mean_rate, want.mean));
          if (mon_out_i.popped_key !== want.pkey)
            report_mismatch($sformatf("popped_key got 0x%h, want 0x%h",
                                      mon_out_i.popped_key, want.pkey));
          if (mon_out_i.popped_rate !== want.prate)
            report_mismatch($sformatf("popped_rate got %0d, want %0d",
                                      mon_out_i.popped_rate, want.prate));
          if (mon_out_i.occupancy !== want.occ)
            report_mismatch($sformatf("occupancy got %0d, want %0d",
                                      mon_out_i.occupancy, want.occ));
        end
      end
      if (mon_in_i.valid === 1'b1 && mon_in_i.ready === 1'b1) begin
        results_due.push_back(apply_request(mon_in_i.opcode, mon_in_i.entry_key,
                                            mon_in_i.entry_rate));
      end
      fail_count_o <= fails;
      pending_o    <= results_due.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives push and pop beats into the ring FIFO with random gaps on both
// channels: a few directed beats for empty pops and extreme keys and rates,
// a fill to full with maximum rates, then blocks that lean to push, pop or
// a mix so the queue wraps, fills and drains many times.
// ----------------------------------------------------------------------------
module testbench;
  import rfra_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int          RANDOM_ITEMS = 750;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          LONG_HOLD    = 300;
  localparam int          HOLD_AT      = 150;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  bit   steady_send;
  bit   steady_recv;

  rfra_in_if  req_ch ();
  rfra_out_if res_ch ();

  ring_fifo_running_average #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  fifo_mean_scoreboard #(.DEPTH(DEPTH)) u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mon_in_i     (req_ch),
    .mon_out_i    (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // mostly random rates, with the extremes drawn often
  function automatic logic [RATE_W-1:0] pick_rate();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return RATE_W'($urandom_range(0, 255));
  endfunction

  task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [RATE_W-1:0] rate);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.entry_key  <= key;
    req_ch.entry_rate <= rate;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
  endtask

  // pending is a registered output of the scoreboard
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // result side: random stalls, some steady stretches, one long hold-off
  initial begin
    int gap;
    int taken;
    taken = 0;
    steady_recv = 1'b0;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken == HOLD_AT) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      if (taken % 40 == 0) steady_recv = ($urandom_range(0, 3) == 0);
      gap = steady_recv ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (res_ch.valid !== 1'b1);
      taken++;
    end
  end

  initial begin
    int sent;
    int block_len;
    int push_pct;
    int kind;
    bit paused;
    steady_send = 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.opcode     <= OP_PUSH;
    req_ch.entry_key  <= '0;
    req_ch.entry_rate <= '0;
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pop, extreme keys and rates, drain back to empty
    send_request(OP_POP, 16'hFFFF, 8'hFF);
    send_request(OP_PUSH, 16'h0000, 8'h00);
    send_request(OP_PUSH, 16'hFFFF, 8'hFF);
    send_request(OP_PUSH, 16'h5555, 8'hAA);
    send_request(OP_PUSH, 16'hAAAA, 8'h55);
    repeat (4) send_request(OP_POP, 16'h0000, 8'h00);
    send_request(OP_POP, 16'h0000, 8'h00);
    send_request(OP_PUSH, 16'h8001, 8'h01);
    send_request(OP_POP, 16'hFFFF, 8'hFF);

    // fill with maximum rates: largest sum, then pushes on a full queue
    steady_send = 1'b1;
    repeat (DEPTH + 2) send_request(OP_PUSH, KEY_W'($urandom_range(0, 16'hFFFF)), 8'hFF);
    sent = DEPTH + 2;

    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 2);
      push_pct = (kind == 0) ? 90 : (kind == 1) ? 10 : 50;
      block_len = $urandom_range(20, 80);
      steady_send = ($urandom_range(0, 3) == 0);
      repeat (block_len) begin
        send_request(($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP,
                     KEY_W'($urandom_range(0, 16'hFFFF)), pick_rate());
        sent++;
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        req_ch.valid <= 1'b0;
        wait_drained();
        paused = 1'b1;
      end
    end

    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
